// ===== design/y2r_pkg.sv =====
// y2r_pkg: constants, stage payload types and the clamp function for yuv422_to_rgb888.
// Stands alone; no dependencies.
`timescale 1ns / 1ps

package y2r_pkg;

   // byte order codes held in the pixel_order register
   localparam logic ORDER_UYVY = 1'b0;
   localparam logic ORDER_YUYV = 1'b1;

   localparam int Q_SHIFT = 16;
   localparam int CTR_W   = 9;   // centred sample, signed
   localparam int COEF_W  = 19;  // signed coefficient
   localparam int PROD_W  = 28;  // product and channel sum, signed
   localparam int WHOLE_W = PROD_W - Q_SHIFT;

   // BT.601 coefficients, Q16
   localparam logic signed [COEF_W-1:0] K_Y  = 19'sd76284;
   localparam logic signed [COEF_W-1:0] K_RV = 19'sd104595;
   localparam logic signed [COEF_W-1:0] K_GV = 19'sd53281;
   localparam logic signed [COEF_W-1:0] K_GU = 19'sd25625;
   localparam logic signed [COEF_W-1:0] K_BU = 19'sd132252;

   localparam logic [8:0] Y_OFFSET = 9'd16;
   localparam logic [8:0] C_OFFSET = 9'd128;
   localparam logic [WHOLE_W-1:0] WHOLE_MAX = WHOLE_W'(255);

   typedef struct packed {
      logic signed [CTR_W-1:0] y0;
      logic signed [CTR_W-1:0] y1;
      logic signed [CTR_W-1:0] u;
      logic signed [CTR_W-1:0] v;
      logic                    last;
   } samples_type;

   typedef struct packed {
      logic signed [PROD_W-1:0] ys0;
      logic signed [PROD_W-1:0] ys1;
      logic signed [PROD_W-1:0] rv;
      logic signed [PROD_W-1:0] gv;
      logic signed [PROD_W-1:0] gu;
      logic signed [PROD_W-1:0] bu;
      logic                     last;
   } prods_type;

   typedef struct packed {
      logic signed [PROD_W-1:0] r0;
      logic signed [PROD_W-1:0] g0;
      logic signed [PROD_W-1:0] b0;
      logic signed [PROD_W-1:0] r1;
      logic signed [PROD_W-1:0] g1;
      logic signed [PROD_W-1:0] b1;
      logic                     last;
   } sums_type;

   typedef struct packed {
      logic [7:0] r0;
      logic [7:0] g0;
      logic [7:0] b0;
      logic [7:0] r1;
      logic [7:0] g1;
      logic [7:0] b1;
      logic       last;
   } pixels_type;

   // drop fraction, clamp to 0..255
   function automatic logic [7:0] clamp_q16(input logic signed [PROD_W-1:0] acc);
      logic [WHOLE_W-1:0] whole;
      whole = acc[PROD_W-1:Q_SHIFT];
      if (acc[PROD_W-1]) begin
         clamp_q16 = 8'd0;
      end else if (whole > WHOLE_MAX) begin
         clamp_q16 = 8'd255;
      end else begin
         clamp_q16 = whole[7:0];
      end
   endfunction

endpackage

// ===== design/yuv422_to_rgb888.sv =====
// yuv422_to_rgb888: BT.601 4:2:2 macropixel to two RGB888 pixels, four-stage pipeline.
// Depends on y2r_pkg (coefficients, stage types, clamp).
`timescale 1ns / 1ps

// One packed macropixel (four bytes, UYVY or YUYV as csr_write_data last set
// pixel_order) goes in per beat, and one beat with two RGB888 pixels comes out.
// Both pixels share the chroma pair; the first uses Y0, the second Y1. Each
// channel is formed in signed Q12.16, the fraction truncated and the result
// clamped to 0..255. frame_end rides alongside and comes out as last_pair.
// Throughput is one beat per clock while rsp_ready holds. A beat passes through the
// four register stages in order (unpack and centre, coefficient multiply, channel
// sums, clamp into the output register); the accepting edge loads stage 1.
// Each stage holds its own valid bit and advances when the stage after it is
// empty or moving, so a stall on rsp_ready fills bubbles before req_ready drops.
// pixel_order is only to be changed with the pipe empty.
module yuv422_to_rgb888 (
   input  logic       clock,
   input  logic       reset,
   // configuration
   input  logic       csr_write_en,
   input  logic       csr_write_data,
   // input beat
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_byte0,
   input  logic [7:0] req_byte1,
   input  logic [7:0] req_byte2,
   input  logic [7:0] req_byte3,
   input  logic       req_frame_end,
   // result beat
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_red_first,
   output logic [7:0] rsp_green_first,
   output logic [7:0] rsp_blue_first,
   output logic [7:0] rsp_red_second,
   output logic [7:0] rsp_green_second,
   output logic [7:0] rsp_blue_second,
   output logic       rsp_last_pair
);

   logic order_ff;

   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff;
   logic s1_ready, s2_ready, s3_ready, s4_ready;

   y2r_pkg::samples_type s1_ff, s1_in;
   y2r_pkg::prods_type   s2_ff, s2_in;
   y2r_pkg::sums_type    s3_ff, s3_in;
   y2r_pkg::pixels_type  s4_ff, s4_in;

   logic [7:0] y0_byte, y1_byte, u_byte, v_byte;

   // ready chain: a stage takes a beat when empty or when it is handing on
   assign s4_ready  = !s4_valid_ff || rsp_ready;
   assign s3_ready  = !s3_valid_ff || s4_ready;
   assign s2_ready  = !s2_valid_ff || s3_ready;
   assign s1_ready  = !s1_valid_ff || s2_ready;
   assign req_ready = s1_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         order_ff <= y2r_pkg::ORDER_UYVY;
      end else if (csr_write_en) begin
         order_ff <= csr_write_data;
      end
   end

   // stage 1: unpack and centre
   always_comb begin
      unique case (order_ff)
         y2r_pkg::ORDER_UYVY: begin
            u_byte  = req_byte0;
            y0_byte = req_byte1;
            v_byte  = req_byte2;
            y1_byte = req_byte3;
         end
         y2r_pkg::ORDER_YUYV: begin
            y0_byte = req_byte0;
            u_byte  = req_byte1;
            y1_byte = req_byte2;
            v_byte  = req_byte3;
         end
         default: begin
            u_byte  = req_byte0;
            y0_byte = req_byte1;
            v_byte  = req_byte2;
            y1_byte = req_byte3;
         end
      endcase
      s1_in.y0   = $signed({1'b0, y0_byte} - y2r_pkg::Y_OFFSET);
      s1_in.y1   = $signed({1'b0, y1_byte} - y2r_pkg::Y_OFFSET);
      s1_in.u    = $signed({1'b0, u_byte} - y2r_pkg::C_OFFSET);
      s1_in.v    = $signed({1'b0, v_byte} - y2r_pkg::C_OFFSET);
      s1_in.last = req_frame_end;
   end

   // stage 2: six coefficient products
   always_comb begin
      s2_in.ys0  = y2r_pkg::PROD_W'(y2r_pkg::K_Y  * s1_ff.y0);
      s2_in.ys1  = y2r_pkg::PROD_W'(y2r_pkg::K_Y  * s1_ff.y1);
      s2_in.rv   = y2r_pkg::PROD_W'(y2r_pkg::K_RV * s1_ff.v);
      s2_in.gv   = y2r_pkg::PROD_W'(y2r_pkg::K_GV * s1_ff.v);
      s2_in.gu   = y2r_pkg::PROD_W'(y2r_pkg::K_GU * s1_ff.u);
      s2_in.bu   = y2r_pkg::PROD_W'(y2r_pkg::K_BU * s1_ff.u);
      s2_in.last = s1_ff.last;
   end

   // stage 3: channel sums, exact in Q12.16
   always_comb begin
      s3_in.r0   = s2_ff.ys0 + s2_ff.rv;
      s3_in.g0   = s2_ff.ys0 - s2_ff.gv - s2_ff.gu;
      s3_in.b0   = s2_ff.ys0 + s2_ff.bu;
      s3_in.r1   = s2_ff.ys1 + s2_ff.rv;
      s3_in.g1   = s2_ff.ys1 - s2_ff.gv - s2_ff.gu;
      s3_in.b1   = s2_ff.ys1 + s2_ff.bu;
      s3_in.last = s2_ff.last;
   end

   // stage 4: truncate and clamp into the output register
   always_comb begin
      s4_in.r0   = y2r_pkg::clamp_q16(s3_ff.r0);
      s4_in.g0   = y2r_pkg::clamp_q16(s3_ff.g0);
      s4_in.b0   = y2r_pkg::clamp_q16(s3_ff.b0);
      s4_in.r1   = y2r_pkg::clamp_q16(s3_ff.r1);
      s4_in.g1   = y2r_pkg::clamp_q16(s3_ff.g1);
      s4_in.b1   = y2r_pkg::clamp_q16(s3_ff.b1);
      s4_in.last = s3_ff.last;
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         if (s1_ready) begin
            s1_valid_ff <= req_valid;
         end
         if (s2_ready) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (s3_ready) begin
            s3_valid_ff <= s2_valid_ff;
         end
         if (s4_ready) begin
            s4_valid_ff <= s3_valid_ff;
         end
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      if (s1_ready && req_valid) begin
         s1_ff <= s1_in;
      end
      if (s2_ready && s1_valid_ff) begin
         s2_ff <= s2_in;
      end
      if (s3_ready && s2_valid_ff) begin
         s3_ff <= s3_in;
      end
      if (s4_ready && s3_valid_ff) begin
         s4_ff <= s4_in;
      end
   end

   assign rsp_valid        = s4_valid_ff;
   assign rsp_red_first    = s4_ff.r0;
   assign rsp_green_first  = s4_ff.g0;
   assign rsp_blue_first   = s4_ff.b0;
   assign rsp_red_second   = s4_ff.r1;
   assign rsp_green_second = s4_ff.g1;
   assign rsp_blue_second  = s4_ff.b1;
   assign rsp_last_pair    = s4_ff.last;

`ifndef SYNTHESIS
   // empty output register means the whole pipe can move
   a_ready_when_out_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("req_ready low with output register empty");

   // a full, stalled pipe must refuse input
   a_full_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s2_valid_ff && s3_valid_ff && s4_valid_ff && !rsp_ready)
      |-> !req_ready)
      else $error("input taken while pipe full and stalled");

   // negative red sum moving into the output clamps to zero
   a_neg_clamp: assert property (@(posedge clock) disable iff (reset)
      (s3_valid_ff && s4_ready && s3_ff.r0[y2r_pkg::PROD_W-1]) |=> (rsp_red_first == 8'd0))
      else $error("negative red sum not clamped to zero");

   // a beat in stage 1 that cannot move stays put
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s2_ready) |=> (s1_valid_ff && $stable(s1_ff)))
      else $error("stage 1 beat lost or changed under stall");

   // nothing comes out right after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("rsp_valid high after reset");
`endif

endmodule
